// File: design/ae_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ae_pkg: shared types and constants of the advantage estimator
// Step record, job descriptor, config register codes, fixed-point helpers.
// ----------------------------------------------------------------------------
package ae_pkg;

    localparam int DATA_W  = 32;
    localparam int COEF_W  = 17;      // Q0.16 with room for 1.0
    localparam int IDX_W   = 6;       // step index on the result channel
    localparam int CFG_IDX_W = 2;

    localparam logic [COEF_W-1:0] COEF_ONE         = 17'd65536;
    localparam logic [COEF_W-1:0] DISCOUNT_RESET   = 17'd64881;
    localparam logic [COEF_W-1:0] TRACE_DECAY_RESET = 17'd62259;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DISCOUNT    = 2'd0,
        CFG_TRACE_DECAY = 2'd1
    } cfg_idx_t;

    typedef logic signed [DATA_W-1:0] q16_t;
    typedef logic [COEF_W-1:0] coef_t;

    // one stored step
    typedef struct packed {
        q16_t reward;
        q16_t value;
        q16_t cut_value;
        logic terminated;
        logic truncated;
    } step_rec_t;

    // one finished trajectory waiting for the backward walk
    typedef struct packed {
        logic [IDX_W-1:0] last_slot;
        logic             bank;
        q16_t             final_value;
    } job_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_GAIN,
        BK_MUL,
        BK_SUM,
        BK_OUT
    } bk_state_t;

    localparam logic signed [35:0] SAT_MAX = 36'sh0_7FFF_FFFF;
    localparam logic signed [35:0] SAT_MIN = 36'shF_8000_0000;

    // Q16.16 x Q0.16 product back to Q16.16, round half up
    function automatic logic signed [33:0] round_q16(input logic signed [49:0] p);
        logic signed [50:0] s;
        s = {p[49], p} + 51'sd32768;
        return s[49:16];
    endfunction

    function automatic q16_t sat32(input logic signed [35:0] x);
        q16_t r;
        if (x > SAT_MAX)
            r = 32'sh7FFF_FFFF;
        else if (x < SAT_MIN)
            r = 32'sh8000_0000;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

// File: design/ae_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ae_if: stream channels of the advantage estimator
// Step channel (trajectory load) and result channel (backward walk output).
// ----------------------------------------------------------------------------
interface ae_step_if;
    import ae_pkg::*;

    logic valid;
    logic ready;
    q16_t reward;
    q16_t value;
    q16_t cut_value;
    logic terminated;
    logic truncated;
    q16_t final_value;
    logic last_step;

    modport source (output valid, reward, value, cut_value, terminated, truncated,
                    final_value, last_step, input ready);
    modport sink (input valid, reward, value, cut_value, terminated, truncated,
                  final_value, last_step, output ready);
endinterface

interface ae_result_if;
    import ae_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] step_index;
    q16_t             advantage;
    q16_t             return_estimate;
    logic             last_result;

    modport source (output valid, step_index, advantage, return_estimate, last_result,
                    input ready);
    modport sink (input valid, step_index, advantage, return_estimate, last_result,
                  output ready);
endinterface

// File: design/ae_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ae_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ae_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

// File: design/ae_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ae_front: trajectory loader
// Writes steps into the free bank, closes a trajectory into a job.
// ----------------------------------------------------------------------------
module ae_front #(
    parameter int MAX_STEPS = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    ae_step_if.sink                 step,
    input  logic                    queue_full,
    output logic                    job_push,
    output ae_pkg::job_t            job,
    output logic                    wr_en,
    output logic [(MAX_STEPS > 1 ? $clog2(MAX_STEPS) : 1):0] wr_addr,
    output ae_pkg::step_rec_t       wr_data
);
    import ae_pkg::*;

    localparam int SLOT_W = MAX_STEPS > 1 ? $clog2(MAX_STEPS) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_STEPS - 1);

    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              bank_reg, bank_next;
    logic              accept;
    logic              finish;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            bank_reg <= 1'b0;
        end
        else
        begin
            slot_reg <= slot_next;
            bank_reg <= bank_next;
        end
    end

    always_comb
    begin
        step.ready = !queue_full;
        accept     = step.valid && !queue_full;
        // a full buffer closes the trajectory as if last_step were set
        finish     = step.last_step || (slot_reg == LAST_SLOT);

        slot_next = slot_reg;
        bank_next = bank_reg;
        if (accept)
        begin
            slot_next = finish ? '0 : slot_reg + 1'b1;
            bank_next = finish ? !bank_reg : bank_reg;
        end

        wr_en   = accept;
        wr_addr = {bank_reg, slot_reg};
        wr_data.reward     = step.reward;
        wr_data.value      = step.value;
        wr_data.cut_value  = step.cut_value;
        wr_data.terminated = step.terminated;
        wr_data.truncated  = step.truncated;

        job_push          = accept && finish;
        job.last_slot     = IDX_W'(slot_reg);
        job.bank          = bank_reg;
        job.final_value   = step.final_value;
    end
endmodule

// File: design/ae_job_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ae_job_fifo: two-entry job queue
// Head stays until the walk of that trajectory is finished.
// ----------------------------------------------------------------------------
module ae_job_fifo (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  ae_pkg::job_t push_job,
    input  logic         pop,
    output logic         head_valid,
    output ae_pkg::job_t head_job,
    output logic         full
);
    import ae_pkg::*;

    job_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
        head_valid  = count_reg != 2'd0;
        full        = count_reg == 2'd2;
        head_job    = entry_reg[rd_ptr_reg];
    end
endmodule

// File: design/ae_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ae_back: backward walk engine
// Walks one stored trajectory newest first, one result beat per step.
// ----------------------------------------------------------------------------
module ae_back #(
    parameter int MAX_STEPS = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    job_valid,
    input  ae_pkg::job_t            job,
    output logic                    job_pop,
    input  ae_pkg::coef_t           discount,
    input  ae_pkg::coef_t           trace_decay,
    output logic [(MAX_STEPS > 1 ? $clog2(MAX_STEPS) : 1):0] rd_addr,
    input  ae_pkg::step_rec_t       rd_data,
    ae_result_if.source             result
);
    import ae_pkg::*;

    localparam int SLOT_W = MAX_STEPS > 1 ? $clog2(MAX_STEPS) : 1;

    bk_state_t          state_reg, state_next;
    logic [SLOT_W-1:0]  t_reg, t_next;
    logic               bank_reg, bank_next;
    q16_t               fv_reg, fv_next;
    q16_t               adv_reg, adv_next;
    logic [33:0]        gl_prod_reg, gl_prod_next;
    coef_t              gl_reg, gl_next;
    logic signed [49:0] p1_reg, p1_next;
    logic signed [49:0] p2_reg, p2_next;
    q16_t               rew_reg, rew_next;
    q16_t               val_reg, val_next;
    logic               term_reg, term_next;
    logic               trunc_reg, trunc_next;

    logic               out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]   out_idx_reg, out_idx_next;
    q16_t               out_adv_reg, out_adv_next;
    q16_t               out_ret_reg, out_ret_next;
    logic               out_last_reg, out_last_next;

    logic [34:0]        gl_round;
    q16_t               boot;
    logic signed [33:0] r1;
    logic signed [33:0] r2;
    logic signed [35:0] acc;
    logic               can_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg        <= t_next;
        bank_reg     <= bank_next;
        fv_reg       <= fv_next;
        adv_reg      <= adv_next;
        gl_prod_reg  <= gl_prod_next;
        gl_reg       <= gl_next;
        p1_reg       <= p1_next;
        p2_reg       <= p2_next;
        rew_reg      <= rew_next;
        val_reg      <= val_next;
        term_reg     <= term_next;
        trunc_reg    <= trunc_next;
        out_idx_reg  <= out_idx_next;
        out_adv_reg  <= out_adv_next;
        out_ret_reg  <= out_ret_next;
        out_last_reg <= out_last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        t_next         = t_reg;
        bank_next      = bank_reg;
        fv_next        = fv_reg;
        adv_next       = adv_reg;
        gl_prod_next   = gl_prod_reg;
        gl_next        = gl_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        rew_next       = rew_reg;
        val_next       = val_reg;
        term_next      = term_reg;
        trunc_next     = trunc_reg;
        out_idx_next   = out_idx_reg;
        out_adv_next   = out_adv_reg;
        out_ret_next   = out_ret_reg;
        out_last_next  = out_last_reg;
        job_pop        = 1'b0;

        can_load       = !out_valid_reg || result.ready;
        out_valid_next = out_valid_reg && !result.ready;

        gl_round = {1'b0, gl_prod_reg} + 35'd32768;
        // cut value only when truncated without a true end
        boot = (rd_data.truncated && !rd_data.terminated) ? rd_data.cut_value : fv_reg;
        r1   = term_reg ? 34'sd0 : round_q16(p1_reg);
        r2   = trunc_reg ? 34'sd0 : round_q16(p2_reg);
        acc  = {{4{rew_reg[31]}}, rew_reg} - {{4{val_reg[31]}}, val_reg}
             + {{2{r1[33]}}, r1} + {{2{r2[33]}}, r2};

        case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    t_next       = SLOT_W'(job.last_slot);
                    bank_next    = job.bank;
                    fv_next      = job.final_value;
                    adv_next     = '0;
                    gl_prod_next = discount * trace_decay;
                    state_next   = BK_GAIN;
                end
            end
            BK_GAIN:
            begin
                gl_next    = gl_round[32:16];
                state_next = BK_MUL;
            end
            BK_MUL:
            begin
                p1_next    = $signed({1'b0, discount}) * boot;
                p2_next    = $signed({1'b0, gl_reg}) * adv_reg;
                rew_next   = rd_data.reward;
                val_next   = rd_data.value;
                term_next  = rd_data.terminated;
                trunc_next = rd_data.truncated;
                state_next = BK_SUM;
            end
            BK_SUM:
            begin
                adv_next   = sat32(acc);
                fv_next    = val_reg;
                state_next = BK_OUT;
            end
            BK_OUT:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = IDX_W'(t_reg);
                    out_adv_next   = adv_reg;
                    out_ret_next   = sat32({{4{adv_reg[31]}}, adv_reg}
                                         + {{4{val_reg[31]}}, val_reg});
                    out_last_next  = t_reg == '0;
                    if (t_reg == '0)
                    begin
                        job_pop    = 1'b1;
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        t_next     = t_reg - 1'b1;
                        state_next = BK_MUL;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        // address of the step the next cycle works on; its registered data arrives then
        rd_addr = {bank_next, t_next};

        result.valid           = out_valid_reg;
        result.step_index      = out_idx_reg;
        result.advantage       = out_adv_reg;
        result.return_estimate = out_ret_reg;
        result.last_result     = out_last_reg;
    end
endmodule

// File: design/advantage_estimator.sv
`timescale 1ns / 1ps
// Load: one step beat per cycle unless the job queue is full; the step
//   store is banked twice, so a new trajectory loads while the previous
//   one is walked. Walk: setup, then multiply, accumulate and emit per step,
//   set by the advantage recurrence: each step's products need the
//   saturated advantage of the step after it. A stalled result holds the emit.
// rst_n (async, active low) clears control state and sets the coefficients
//   to their defaults; step store contents are left as they are.
// ----------------------------------------------------------------------------
// advantage_estimator: generalized advantage estimation over one trajectory
// Front loads steps into a banked store, a two-entry job queue hands closed
// trajectories to the back end, which walks them newest first in Q16.16.
// ----------------------------------------------------------------------------
module advantage_estimator #(
    parameter int MAX_STEPS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    ae_step_if.sink                     step,
    ae_result_if.source                 result,
    input  logic                        cfg_write,
    input  logic [ae_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ae_pkg::COEF_W-1:0]   cfg_data
);
    import ae_pkg::*;

    localparam int SLOT_W = MAX_STEPS > 1 ? $clog2(MAX_STEPS) : 1;
    localparam int ADDR_W = SLOT_W + 1;           // bank bit plus slot
    localparam int RAM_DEPTH = 2 ** ADDR_W;

    // Coefficient registers. Writes above 1.0 are clamped to 1.0;
    // writes to an unknown index are dropped.
    coef_t discount_reg, discount_next;
    coef_t trace_decay_reg, trace_decay_next;
    coef_t cfg_clamped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            discount_reg    <= DISCOUNT_RESET;
            trace_decay_reg <= TRACE_DECAY_RESET;
        end
        else
        begin
            discount_reg    <= discount_next;
            trace_decay_reg <= trace_decay_next;
        end
    end

    always_comb
    begin
        cfg_clamped      = (cfg_data > COEF_ONE) ? COEF_ONE : cfg_data;
        discount_next    = discount_reg;
        trace_decay_next = trace_decay_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_DISCOUNT:    discount_next    = cfg_clamped;
                CFG_TRACE_DECAY: trace_decay_next = cfg_clamped;
                default:         ;
            endcase
        end
    end

    // Front end to queue and store
    logic              job_push;
    job_t              push_job;
    logic              queue_full;
    logic              job_valid;
    job_t              head_job;
    logic              job_pop;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    step_rec_t         wr_data;
    logic [ADDR_W-1:0] rd_addr;
    step_rec_t         rd_data;

    ae_front #(
        .MAX_STEPS (MAX_STEPS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .queue_full (queue_full),
        .job_push   (job_push),
        .job        (push_job),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    // A job stays at the head until its walk is done, so the queue count
    // is also the number of banks in use: the front stalls when both are.
    ae_job_fifo u_jobs (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (job_push),
        .push_job   (push_job),
        .pop        (job_pop),
        .head_valid (job_valid),
        .head_job   (head_job),
        .full       (queue_full)
    );

    // All five per-step fields share one wide word
    ae_ram #(
        .WIDTH ($bits(step_rec_t)),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ae_back #(
        .MAX_STEPS (MAX_STEPS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (job_valid),
        .job         (head_job),
        .job_pop     (job_pop),
        .discount    (discount_reg),
        .trace_decay (trace_decay_reg),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .result      (result)
    );
endmodule

// File: design/ae_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ae_checker: port-level checks of the advantage estimator
// Result channel behavior across reset and stalls.
// ----------------------------------------------------------------------------
module ae_checker (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     res_valid,
    input logic                     res_ready,
    input logic [ae_pkg::IDX_W-1:0] res_step_index,
    input logic [31:0]              res_advantage,
    input logic [31:0]              res_return,
    input logic                     res_last
);
    // no beat offered on the cycle after reset is seen
    a_no_result_in_reset: assert property (@(posedge clk) !rst_n |=> !res_valid)
        else $error("result valid during reset");

    // the closing beat of a walk is always time zero
    a_last_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_last |-> res_step_index == '0)
        else $error("last result with nonzero step index");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_step_index) && $stable(res_advantage)
            && $stable(res_return) && $stable(res_last))
        else $error("result payload changed while stalled");
endmodule

bind advantage_estimator ae_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .res_step_index (result.step_index),
    .res_advantage  (result.advantage),
    .res_return     (result.return_estimate),
    .res_last       (result.last_result)
);

// File: verif/advantage_estimator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// advantage_estimator_tb: self-checking bench for the advantage estimator
// Loads trajectories of Q16.16 steps, predicts the backward GAE walk in
// software and checks every result beat in order, across several gamma and
// lambda settings, with random gaps on the step side and stalls on results.
// ----------------------------------------------------------------------------
module advantage_estimator_tb;
    import ae_pkg::*;

    localparam int STEP_DEPTH    = 64;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 22;     // minimum steps sent per phase
    localparam int MAX_GAP       = 8;      // longest sender gap
    localparam int MAX_STALL     = 16;     // longest receiver stall
    // Idle time once the last predicted beat has shown up; well past the
    // tail of any walk.
    localparam int SETTLE_CYCLES = 24;
    // Longest legal quiet stretch: sender gap + walk setup + one step +
    // receiver stall + settle time. Take a wide margin.
    localparam int QUIET_LIMIT   = 4000;

    // Spare register indexes: writes there must leave both coefficients alone
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam q16_t Q_MAX = 32'sh7FFF_FFFF;
    localparam q16_t Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        q16_t reward;
        q16_t value;
        q16_t cut_value;
        logic terminated;
        logic truncated;
        q16_t final_value;
        logic last_step;
    } step_beat_t;

    typedef struct packed {
        logic [IDX_W-1:0] step_index;
        q16_t             advantage;
        q16_t             return_estimate;
        logic             last_result;
    } adv_result_t;

    typedef enum int {RX_OPEN, RX_RANDOM, RX_STALLS} rx_mode_t;

    // ------------------------------------------------------------------------
    // Software copy of the estimator: buffers steps, runs the backward walk
    // when a trajectory closes and queues the advantages it should emit.
    // ------------------------------------------------------------------------
    class advantage_predictor;
        int unsigned discount;
        int unsigned trace_decay;
        q16_t        rewards [STEP_DEPTH];
        q16_t        values  [STEP_DEPTH];
        q16_t        cuts    [STEP_DEPTH];
        bit          terms   [STEP_DEPTH];
        bit          truncs  [STEP_DEPTH];
        int          fill;
        adv_result_t pending_advantages[$];
        int          errors;

        function new();
            discount    = DISCOUNT_RESET;
            trace_decay = TRACE_DECAY_RESET;
            fill        = 0;
            errors      = 0;
        endfunction

        // floor((p + 0.5 LSB) / 2^16)
        static function longint round_half_up(longint p);
            return (p + 64'sd32768) >>> 16;
        endfunction

        static function q16_t clamp_q16(longint x);
            if (x > longint'(Q_MAX))
                return Q_MAX;
            if (x < longint'(Q_MIN))
                return Q_MIN;
            return q16_t'(x);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, coef_t data);
            int unsigned v;
            v = (data > COEF_ONE) ? COEF_ONE : data;   // above 1.0 reads as 1.0
            case (idx)
                CFG_DISCOUNT:    discount = v;
                CFG_TRACE_DECAY: trace_decay = v;
                default:         ;
            endcase
        endfunction

        function void load_step(step_beat_t s);
            int          slot;
            longint      gl;
            longint      boot;
            longint      acc;
            q16_t        follow;
            q16_t        run_adv;
            adv_result_t r;
            slot = (fill < STEP_DEPTH) ? fill : STEP_DEPTH - 1;
            rewards[slot] = s.reward;
            values[slot]  = s.value;
            cuts[slot]    = s.cut_value;
            terms[slot]   = s.terminated;
            truncs[slot]  = s.truncated;
            fill = slot + 1;
            // a full buffer closes the trajectory as if last_step were set
            if (!s.last_step && fill < STEP_DEPTH)
                return;

            gl      = round_half_up(longint'(discount) * longint'(trace_decay));
            follow  = s.final_value;
            run_adv = '0;
            for (int t = fill - 1; t >= 0; t--) begin
                // truncated but not terminated: bootstrap from its own cut value
                boot = (truncs[t] && !terms[t]) ? longint'(cuts[t]) : longint'(follow);
                acc  = longint'(rewards[t]) - longint'(values[t]);
                if (!terms[t])
                    acc += round_half_up(longint'(discount) * boot);
                if (!truncs[t])
                    acc += round_half_up(gl * longint'(run_adv));
                run_adv  = clamp_q16(acc);
                follow   = values[t];
                r.step_index      = IDX_W'(t);
                r.advantage       = run_adv;
                r.return_estimate = clamp_q16(longint'(run_adv) + longint'(values[t]));
                r.last_result     = (t == 0);
                pending_advantages.push_back(r);
            end
            fill = 0;
        endfunction

        function void check_result(adv_result_t got);
            adv_result_t want;
            if (pending_advantages.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: idx %0d adv %h ret %h last %b",
                             got.step_index, got.advantage, got.return_estimate,
                             got.last_result);
                return;
            end
            want = pending_advantages.pop_front();
            if (got.step_index !== want.step_index || got.advantage !== want.advantage ||
                got.return_estimate !== want.return_estimate ||
                got.last_result !== want.last_result) begin
                errors++;
                if (errors <= 10)
                    $display("result mismatch: idx %0d/%0d adv %h/%h ret %h/%h last %b/%b",
                             want.step_index, got.step_index, want.advantage, got.advantage,
                             want.return_estimate, got.return_estimate,
                             want.last_result, got.last_result);
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    coef_t                cfg_data;

    ae_step_if   step_ch();
    ae_result_if result_ch();

    advantage_predictor predictor;
    adv_result_t        seen_result;

    int       burst_left   = 0;
    int       quiet_cycles = 0;
    rx_mode_t rx_mode      = RX_OPEN;
    int       mode_left    = 0;
    int       stall_left   = 0;

    advantage_estimator #(
        .MAX_STEPS (STEP_DEPTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step_ch),
        .result    (result_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Result side: ready follows a pattern of its own. Modes switch at random
    // between always ready, mostly ready at random and long stalls, so
    // back-pressure lands on every phase of the walk.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            rx_mode   = rx_mode_t'($urandom_range(0, 2));
            mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (rx_mode)
            RX_OPEN:   result_ch.ready <= 1'b1;
            RX_RANDOM: result_ch.ready <= ($urandom_range(0, 3) != 0);
            default:
            begin
                if (stall_left > 0)
                begin
                    stall_left--;
                    result_ch.ready <= 1'b0;
                end
                else
                begin
                    result_ch.ready <= 1'b1;
                    if ($urandom_range(0, 3) == 0)
                        stall_left = $urandom_range(1, MAX_STALL);
                end
            end
        endcase
    end

    // Every accepted result beat goes straight to the checker.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            seen_result.step_index      = result_ch.step_index;
            seen_result.advantage       = result_ch.advantage;
            seen_result.return_estimate = result_ch.return_estimate;
            seen_result.last_result     = result_ch.last_result;
            predictor.check_result(seen_result);
        end
    end

    // Watchdog: any beat or register write counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || cfg_write || (step_ch.valid && step_ch.ready) ||
            (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Mix of full-range words, small values near zero and the corner words,
    // so sums both saturate and stay exact.
    function automatic q16_t rand_q16();
        q16_t r;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 3))
                    0:       r = Q_MAX;
                    1:       r = Q_MIN;
                    2:       r = '0;
                    default: r = -32'sd1;
                endcase
            end
            1, 2, 3, 4: r = q16_t'($urandom);
            default:    r = q16_t'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
        endcase
        return r;
    endfunction

    function automatic step_beat_t make_step(q16_t rw, q16_t v, q16_t cv, logic term,
                                              logic trunc, q16_t fv, logic last);
        step_beat_t b;
        b.reward      = rw;
        b.value       = v;
        b.cut_value   = cv;
        b.terminated  = term;
        b.truncated   = trunc;
        b.final_value = fv;
        b.last_step   = last;
        return b;
    endfunction

    // One step beat. Called at a falling edge, returns at a falling edge.
    // Bursts of random length, separated by random gaps (often none).
    task automatic send_step(input step_beat_t b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, MAX_GAP);
            if (gap > 0)
            begin
                step_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        step_ch.valid       <= 1'b1;
        step_ch.reward      <= b.reward;
        step_ch.value       <= b.value;
        step_ch.cut_value   <= b.cut_value;
        step_ch.terminated  <= b.terminated;
        step_ch.truncated   <= b.truncated;
        step_ch.final_value <= b.final_value;
        step_ch.last_step   <= b.last_step;
        @(posedge clk);
        while (!step_ch.ready)
            @(posedge clk);
        predictor.load_step(b);
        @(negedge clk);
    endtask

    // Random trajectory; mark_end puts last_step on the final beat only.
    task automatic send_trajectory(input int len, input bit mark_end);
        step_beat_t b;
        for (int i = 0; i < len; i++)
        begin
            b.reward      = rand_q16();
            b.value       = rand_q16();
            b.cut_value   = rand_q16();
            b.terminated  = ($urandom_range(0, 3) == 0);
            b.truncated   = ($urandom_range(0, 3) == 0);
            b.final_value = rand_q16();
            b.last_step   = mark_end && (i == len - 1);
            send_step(b);
        end
    endtask

    // Park the step side and let the walk finish before touching registers.
    task automatic drain_results();
        step_ch.valid <= 1'b0;
        while (predictor.pending_advantages.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Back-to-back writes keep cfg_write high; the caller drops it.
    task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input coef_t data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        predictor.write_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic configure(input int phase);
        case (phase)
            1:
            begin
                write_coef(CFG_DISCOUNT, COEF_ONE);
                write_coef(CFG_TRACE_DECAY, COEF_ONE);
            end
            2:
            begin
                write_coef(CFG_DISCOUNT, '0);
                write_coef(CFG_TRACE_DECAY, '0);
            end
            3:
            begin
                // all-ones data clamps to 1.0; spare indexes are dropped
                write_coef(CFG_DISCOUNT, 17'h1FFFF);
                write_coef(CFG_TRACE_DECAY, '0);
                write_coef(CFG_SPARE_A, coef_t'($urandom));
                write_coef(CFG_SPARE_B, coef_t'($urandom));
            end
            4:
            begin
                write_coef(CFG_DISCOUNT, '0);
                write_coef(CFG_TRACE_DECAY, COEF_ONE + 17'd1);
            end
            5:
            begin
                write_coef(CFG_DISCOUNT, coef_t'($urandom_range(0, COEF_ONE)));
                write_coef(CFG_TRACE_DECAY, coef_t'($urandom_range(0, COEF_ONE)));
            end
            6:
            begin
                write_coef(CFG_DISCOUNT, coef_t'($urandom_range(0, 17'h1FFFF)));
                write_coef(CFG_TRACE_DECAY, coef_t'($urandom_range(0, 17'h1FFFF)));
            end
            7:
            begin
                write_coef(CFG_TRACE_DECAY, COEF_ONE);
                write_coef(CFG_DISCOUNT, coef_t'($urandom_range(0, COEF_ONE)));
                write_coef(CFG_SPARE_B, COEF_ONE);
            end
            default: ;   // phase 0 runs on the reset coefficients
        endcase
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        int sent;
        int len;
        predictor = new();

        rst_n               = 1'b0;
        cfg_write           = 1'b0;
        cfg_index           = CFG_DISCOUNT;
        cfg_data            = '0;
        step_ch.valid       = 1'b0;
        step_ch.reward      = '0;
        step_ch.value       = '0;
        step_ch.cut_value   = '0;
        step_ch.terminated  = 1'b0;
        step_ch.truncated   = 1'b0;
        step_ch.final_value = '0;
        step_ch.last_step   = 1'b0;
        result_ch.ready     = 1'b0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // --- directed, on reset coefficients ---
        // single-step trajectories driven into both saturation rails
        send_step(make_step(Q_MAX, Q_MIN, Q_MAX, 1'b0, 1'b0, Q_MAX, 1'b1));
        send_step(make_step(Q_MIN, Q_MAX, Q_MIN, 1'b0, 1'b0, Q_MIN, 1'b1));
        // terminated and truncated together: final value must be ignored
        send_step(make_step(32'sh0002_0000, 32'sh0001_0000, Q_MAX, 1'b1, 1'b1, Q_MAX,
                            1'b1));
        // every flag combination in one trajectory
        send_step(make_step(32'sh0001_0000, 32'sh0002_8000, 32'sh0010_0000, 1'b0, 1'b0,
                            '0, 1'b0));
        send_step(make_step(-32'sh0001_0000, 32'sh0000_4000, Q_MAX, 1'b1, 1'b0, '0, 1'b0));
        send_step(make_step(32'sh0003_0000, -32'sh0001_8000, 32'sh0005_0000, 1'b0, 1'b1,
                            '0, 1'b0));
        send_step(make_step(32'sh0000_8000, 32'sh0001_0000, Q_MIN, 1'b1, 1'b1,
                            32'sh0004_0000, 1'b1));
        // same combinations in reverse order with all-ones and corner words
        send_step(make_step(-32'sd1, '0, -32'sd1, 1'b1, 1'b1, -32'sd1, 1'b0));
        send_step(make_step('0, -32'sd1, Q_MAX, 1'b0, 1'b1, '0, 1'b0));
        send_step(make_step(Q_MAX, Q_MAX, Q_MIN, 1'b1, 1'b0, '0, 1'b0));
        send_step(make_step(Q_MIN, Q_MIN, '0, 1'b0, 1'b0, Q_MAX, 1'b1));
        // negative rail carried backward through the trace term
        send_step(make_step(Q_MIN, Q_MAX, '0, 1'b0, 1'b0, '0, 1'b0));
        send_step(make_step(Q_MIN, Q_MAX, '0, 1'b0, 1'b0, Q_MIN, 1'b1));

        // --- random phases, one coefficient setting each ---
        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_results();
            configure(phase);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 30)
                                                  : $urandom_range(1, 10);
                send_trajectory(len, 1'b1);
                sent += len;
            end
            // full buffer closes the trajectory with no last_step; the
            // three beats after it form a fresh one
            if (phase == 4)
                send_trajectory(STEP_DEPTH + 3, 1'b1);
            // full buffer and last_step on the same beat
            if (phase == 6)
                send_trajectory(STEP_DEPTH, 1'b1);
        end

        drain_results();
        if (predictor.errors == 0 && predictor.pending_advantages.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: advantage_estimator.f
design/ae_pkg.sv
design/ae_if.sv
design/ae_ram.sv
design/ae_front.sv
design/ae_job_fifo.sv
design/ae_back.sv
design/advantage_estimator.sv
design/ae_checker.sv
verif/advantage_estimator_tb.sv
